FILE: rtl/cfcp_pkg.sv
// Shared types and constants of the friction cone projection block.
package cfcp_pkg;

	localparam int CFG_W = 32;
	localparam int DIV_W = 64;
	localparam int DVS_W = 32;
	localparam int SQRT_STEPS = 32;

	typedef enum logic [2:0] {
		REG_NN   = 3'd0,
		REG_NT_A = 3'd1,
		REG_NT_B = 3'd2,
		REG_TT_A = 3'd3,
		REG_TT_B = 3'd4,
		REG_MU   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] viol_normal;
		logic signed [31:0] viol_tangent_a;
		logic signed [31:0] viol_tangent_b;
		logic signed [31:0] prev_force_normal;
		logic signed [31:0] prev_force_tangent_a;
		logic signed [31:0] prev_force_tangent_b;
	} req_t;

	typedef struct packed {
		logic        [30:0] new_force_normal;
		logic signed [31:0] new_force_tangent_a;
		logic signed [31:0] new_force_tangent_b;
		logic signed [31:0] new_viol_tangent_a;
		logic signed [31:0] new_viol_tangent_b;
		logic               contact_active;
	} rsp_t;

	// Per-contact context that travels along the pipeline with each request.
	typedef struct packed {
		logic               rel;
		logic               sgn_n;
		logic               sgn_a;
		logic               sgn_b;
		logic               r_small;
		logic               need;
		logic        [30:0] fn;
		logic signed [31:0] pn;
		logic signed [31:0] pa;
		logic signed [31:0] pb;
		logic signed [31:0] va_in;
		logic signed [31:0] vb_in;
		logic signed [31:0] va;
		logic signed [31:0] vb;
		logic signed [31:0] fa;
		logic signed [31:0] fb;
		logic        [31:0] ma;
		logic        [31:0] mb;
		logic        [31:0] r;
		logic        [31:0] norm;
	} ctx_t;

endpackage

FILE: rtl/cfcp_if.sv
// Request and response channel interfaces of the friction cone projection block.
interface cfcp_req_if;
	logic           valid;
	logic           ready;
	cfcp_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cfcp_rsp_if;
	logic           valid;
	logic           ready;
	cfcp_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/cfcp_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
module cfcp_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic [1:0][cfcp_pkg::DIV_W-1:0]        dividend,
	input  logic [1:0][cfcp_pkg::DVS_W-1:0]        divisor,
	input  cfcp_pkg::ctx_t                         ctx_in,
	output logic                                   out_valid,
	output logic [1:0][cfcp_pkg::DIV_W-1:0]        quotient,
	output cfcp_pkg::ctx_t                         ctx_out
);

	logic                                 v_q   [1:cfcp_pkg::DIV_W];
	logic [1:0][cfcp_pkg::DVS_W-1:0]      rem_q [1:cfcp_pkg::DIV_W];
	logic [1:0][cfcp_pkg::DIV_W-1:0]      dq_q  [1:cfcp_pkg::DIV_W];
	logic [1:0][cfcp_pkg::DVS_W-1:0]      dvs_q [1:cfcp_pkg::DIV_W];
	cfcp_pkg::ctx_t                       ctx_q [1:cfcp_pkg::DIV_W];

	for (genvar k = 0; k < cfcp_pkg::DIV_W; k++) begin : g_stage
		logic                            v_c;
		logic [1:0][cfcp_pkg::DVS_W-1:0] rem_c;
		logic [1:0][cfcp_pkg::DIV_W-1:0] dq_c;
		logic [1:0][cfcp_pkg::DVS_W-1:0] dvs_c;
		cfcp_pkg::ctx_t                  ctx_c;
		logic [1:0][cfcp_pkg::DVS_W:0]   t;
		logic [1:0][cfcp_pkg::DVS_W-1:0] rem_n;
		logic [1:0][cfcp_pkg::DIV_W-1:0] dq_n;

		if (k == 0) begin : g_first
			assign v_c   = in_valid;
			assign rem_c = '0;
			assign dq_c  = dividend;
			assign dvs_c = divisor;
			assign ctx_c = ctx_in;
		end else begin : g_rest
			assign v_c   = v_q[k];
			assign rem_c = rem_q[k];
			assign dq_c  = dq_q[k];
			assign dvs_c = dvs_q[k];
			assign ctx_c = ctx_q[k];
		end

		// Shift in the next dividend bit and subtract the divisor when it fits.
		always_comb begin
			for (int l = 0; l < 2; l++) begin
				t[l] = {rem_c[l], dq_c[l][cfcp_pkg::DIV_W-1]};
				if (t[l] >= {1'b0, dvs_c[l]}) begin
					rem_n[l] = cfcp_pkg::DVS_W'(t[l] - {1'b0, dvs_c[l]});
					dq_n[l]  = {dq_c[l][cfcp_pkg::DIV_W-2:0], 1'b1};
				end else begin
					rem_n[l] = t[l][cfcp_pkg::DVS_W-1:0];
					dq_n[l]  = {dq_c[l][cfcp_pkg::DIV_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= rem_n;
				dq_q[k+1]  <= dq_n;
				dvs_q[k+1] <= dvs_c;
				ctx_q[k+1] <= ctx_c;
			end
		end
	end

	assign out_valid = v_q[cfcp_pkg::DIV_W];
	assign quotient  = dq_q[cfcp_pkg::DIV_W];
	assign ctx_out   = ctx_q[cfcp_pkg::DIV_W];

endmodule

FILE: rtl/contact_friction_cone_projection.sv
// Top level: Gauss-Seidel contact step with Coulomb friction cone projection.
//
//   channel | direction | handshake       | payload
//   req     | in        | valid / ready   | violations and previous forces
//   rsp     | out       | valid / ready   | new forces, new violations, active flag
//   cfg     | in        | cfg_we          | cfg_idx, cfg_wdata
//
// One request enters every cycle while the response is not held; the pipeline is
// built from three 64-stage dividers, a 32-stage square root and ten arithmetic stages.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// When the response is held, the whole pipeline freezes and req.ready drops;
// nothing is lost or repeated.
module contact_friction_cone_projection (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_idx,
	input  logic [cfcp_pkg::CFG_W-1:0]   cfg_wdata,
	cfcp_req_if.sink                     req,
	cfcp_rsp_if.source                   rsp
);

	localparam int SQ = cfcp_pkg::SQRT_STEPS;

	logic        [30:0] nn_q;
	logic signed [31:0] nt_a_q;
	logic signed [31:0] nt_b_q;
	logic        [29:0] tt_a_q;
	logic        [29:0] tt_b_q;
	logic        [20:0] mu_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nn_q   <= 31'd65536;
			nt_a_q <= '0;
			nt_b_q <= '0;
			tt_a_q <= 30'd65536;
			tt_b_q <= 30'd65536;
			mu_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				cfcp_pkg::REG_NN:   nn_q   <= cfg_wdata[30:0];
				cfcp_pkg::REG_NT_A: nt_a_q <= cfg_wdata;
				cfcp_pkg::REG_NT_B: nt_b_q <= cfg_wdata;
				cfcp_pkg::REG_TT_A: tt_a_q <= cfg_wdata[29:0];
				cfcp_pkg::REG_TT_B: tt_b_q <= cfg_wdata[29:0];
				cfcp_pkg::REG_MU:   mu_q   <= cfg_wdata[20:0];
				default: ;
			endcase
		end
	end

	// Divisors, with a zero divisor taken as one.
	logic [31:0] nn_div;
	logic [30:0] tsum;
	logic [31:0] ts_div;
	assign nn_div = (nn_q == '0) ? 32'd1 : {1'b0, nn_q};
	assign tsum   = 31'(tt_a_q) + 31'(tt_b_q);
	assign ts_div = (tsum == '0) ? 32'd1 : {1'b0, tsum};

	// The pipeline advances when the response register is free.
	logic adv;
	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	// Stage 1: request register.
	logic           v_s1;
	cfcp_pkg::req_t in_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1 <= req.data;
		end
	end

	// Normal division: |viol_n| * 2^16 / nn.
	logic [31:0]                     mag_vn;
	cfcp_pkg::ctx_t                  ctx_a_in;
	logic [1:0][cfcp_pkg::DIV_W-1:0] a_dvd;
	logic [1:0][cfcp_pkg::DVS_W-1:0] a_dvs;
	logic                            a_v;
	logic [1:0][cfcp_pkg::DIV_W-1:0] a_q;
	cfcp_pkg::ctx_t                  a_ctx;
	always_comb begin
		mag_vn         = in_s1.viol_normal[31] ? (~in_s1.viol_normal + 32'd1)
		                                       : in_s1.viol_normal;
		ctx_a_in       = '0;
		ctx_a_in.sgn_n = in_s1.viol_normal[31];
		ctx_a_in.pn    = in_s1.prev_force_normal;
		ctx_a_in.pa    = in_s1.prev_force_tangent_a;
		ctx_a_in.pb    = in_s1.prev_force_tangent_b;
		ctx_a_in.va_in = in_s1.viol_tangent_a;
		ctx_a_in.vb_in = in_s1.viol_tangent_b;
		a_dvd[0]       = {16'd0, mag_vn, 16'd0};
		a_dvd[1]       = '0;
		a_dvs[0]       = nn_div;
		a_dvs[1]       = 32'd1;
	end

	cfcp_div u_div_n (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s1),
		.dividend(a_dvd), .divisor(a_dvs), .ctx_in(ctx_a_in),
		.out_valid(a_v), .quotient(a_q), .ctx_out(a_ctx)
	);

	// Stage 2: wide normal force.
	logic signed [49:0] qn;
	logic               v_s2;
	cfcp_pkg::ctx_t     ctx_s2;
	logic signed [49:0] fnw_s2;
	assign qn = a_ctx.sgn_n ? -$signed({2'b00, a_q[0][47:0]}) : $signed({2'b00, a_q[0][47:0]});
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= a_v;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s2 <= a_ctx;
			fnw_s2 <= 50'(a_ctx.pn) - qn;
		end
	end

	// Stage 3: release test, saturation and change of normal force.
	logic        [30:0] fn_c;
	cfcp_pkg::ctx_t     ctx_c3;
	logic               v_s3;
	cfcp_pkg::ctx_t     ctx_s3;
	logic signed [32:0] dn_s3;
	always_comb begin
		if (fnw_s2[49]) begin
			fn_c = '0;
		end else if (fnw_s2 > 50'sh7FFFFFFF) begin
			fn_c = 31'h7FFFFFFF;
		end else begin
			fn_c = fnw_s2[30:0];
		end
		ctx_c3     = ctx_s2;
		ctx_c3.rel = fnw_s2[49];
		ctx_c3.fn  = fn_c;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3 <= ctx_c3;
			dn_s3  <= $signed({2'b00, fn_c}) - 33'(ctx_s2.pn);
		end
	end

	// Stage 4: coupling products and cone radius product.
	logic               v_s4;
	cfcp_pkg::ctx_t     ctx_s4;
	logic signed [64:0] pra_s4;
	logic signed [64:0] prb_s4;
	logic        [51:0] rw_c;
	logic        [35:0] r_s4;
	assign rw_c = 52'(ctx_s3.fn) * 52'(mu_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s4 <= ctx_s3;
			pra_s4 <= 65'(nt_a_q) * 65'(dn_s3);
			prb_s4 <= 65'(nt_b_q) * 65'(dn_s3);
			r_s4   <= rw_c[51:16];
		end
	end

	// Stage 5: updated tangent violations, saturated.
	logic signed [49:0] suma;
	logic signed [49:0] sumb;
	logic signed [31:0] va_c;
	logic signed [31:0] vb_c;
	cfcp_pkg::ctx_t     ctx_c5;
	logic               v_s5;
	cfcp_pkg::ctx_t     ctx_s5;
	always_comb begin
		suma = 50'(ctx_s4.va_in) + 50'(pra_s4 >>> 16);
		sumb = 50'(ctx_s4.vb_in) + 50'(prb_s4 >>> 16);
		if (suma > 50'sh7FFFFFFF) begin
			va_c = 32'sh7FFFFFFF;
		end else if (suma < -50'sh80000000) begin
			va_c = 32'sh80000000;
		end else begin
			va_c = suma[31:0];
		end
		if (sumb > 50'sh7FFFFFFF) begin
			vb_c = 32'sh7FFFFFFF;
		end else if (sumb < -50'sh80000000) begin
			vb_c = 32'sh80000000;
		end else begin
			vb_c = sumb[31:0];
		end
		ctx_c5         = ctx_s4;
		ctx_c5.va      = va_c;
		ctx_c5.vb      = vb_c;
		ctx_c5.r       = r_s4[31:0];
		ctx_c5.r_small = (r_s4[35:32] == '0);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s5 <= ctx_c5;
		end
	end

	// Tangent division: |2 * viol_t| * 2^16 / (tt_first + tt_second).
	logic [31:0]                     mag_va;
	logic [31:0]                     mag_vb;
	cfcp_pkg::ctx_t                  ctx_b_in;
	logic [1:0][cfcp_pkg::DIV_W-1:0] b_dvd;
	logic [1:0][cfcp_pkg::DVS_W-1:0] b_dvs;
	logic                            b_v;
	logic [1:0][cfcp_pkg::DIV_W-1:0] b_q;
	cfcp_pkg::ctx_t                  b_ctx;
	always_comb begin
		mag_va         = ctx_s5.va[31] ? (~ctx_s5.va + 32'd1) : ctx_s5.va;
		mag_vb         = ctx_s5.vb[31] ? (~ctx_s5.vb + 32'd1) : ctx_s5.vb;
		ctx_b_in       = ctx_s5;
		ctx_b_in.sgn_a = ctx_s5.va[31];
		ctx_b_in.sgn_b = ctx_s5.vb[31];
		b_dvd[0]       = {15'd0, mag_va, 17'd0};
		b_dvd[1]       = {15'd0, mag_vb, 17'd0};
		b_dvs[0]       = ts_div;
		b_dvs[1]       = ts_div;
	end

	cfcp_div u_div_t (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s5),
		.dividend(b_dvd), .divisor(b_dvs), .ctx_in(ctx_b_in),
		.out_valid(b_v), .quotient(b_q), .ctx_out(b_ctx)
	);

	// Stage 6: corrected tangent forces, saturated.
	logic signed [51:0] qa;
	logic signed [51:0] qb;
	logic signed [51:0] faw;
	logic signed [51:0] fbw;
	logic signed [31:0] fa_c;
	logic signed [31:0] fb_c;
	cfcp_pkg::ctx_t     ctx_c6;
	logic               v_s6;
	cfcp_pkg::ctx_t     ctx_s6;
	always_comb begin
		qa  = b_ctx.sgn_a ? -$signed({3'b000, b_q[0][48:0]}) : $signed({3'b000, b_q[0][48:0]});
		qb  = b_ctx.sgn_b ? -$signed({3'b000, b_q[1][48:0]}) : $signed({3'b000, b_q[1][48:0]});
		faw = 52'(b_ctx.pa) - qa;
		fbw = 52'(b_ctx.pb) - qb;
		if (faw > 52'sh7FFFFFFF) begin
			fa_c = 32'sh7FFFFFFF;
		end else if (faw < -52'sh80000000) begin
			fa_c = 32'sh80000000;
		end else begin
			fa_c = faw[31:0];
		end
		if (fbw > 52'sh7FFFFFFF) begin
			fb_c = 32'sh7FFFFFFF;
		end else if (fbw < -52'sh80000000) begin
			fb_c = 32'sh80000000;
		end else begin
			fb_c = fbw[31:0];
		end
		ctx_c6    = b_ctx;
		ctx_c6.fa = fa_c;
		ctx_c6.fb = fb_c;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= b_v;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s6 <= ctx_c6;
		end
	end

	// Stage 7: magnitudes and squares for the cone test.
	logic [31:0]    ma_c;
	logic [31:0]    mb_c;
	cfcp_pkg::ctx_t ctx_c7;
	logic           v_s7;
	cfcp_pkg::ctx_t ctx_s7;
	logic [63:0]    sqa_s7;
	logic [63:0]    sqb_s7;
	logic [63:0]    rr_s7;
	assign ma_c = ctx_s6.fa[31] ? (~ctx_s6.fa + 32'd1) : ctx_s6.fa;
	assign mb_c = ctx_s6.fb[31] ? (~ctx_s6.fb + 32'd1) : ctx_s6.fb;
	always_comb begin
		ctx_c7    = ctx_s6;
		ctx_c7.ma = ma_c;
		ctx_c7.mb = mb_c;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s7 <= ctx_c7;
			sqa_s7 <= 64'(ma_c) * 64'(ma_c);
			sqb_s7 <= 64'(mb_c) * 64'(mb_c);
			rr_s7  <= 64'(ctx_s6.r) * 64'(ctx_s6.r);
		end
	end

	// Stage 8: squared norm and the decision to scale.
	logic [63:0]    sq_c;
	cfcp_pkg::ctx_t ctx_c8;
	logic           v_s8;
	cfcp_pkg::ctx_t ctx_s8;
	logic [63:0]    sq_s8;
	assign sq_c = sqa_s7 + sqb_s7;
	always_comb begin
		ctx_c8      = ctx_s7;
		ctx_c8.need = ctx_s7.r_small && (sq_c > rr_s7);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s8 <= ctx_c8;
			sq_s8  <= sq_c;
		end
	end

	// Floor square root, two radicand bits per stage.
	logic           rt_v    [1:SQ];
	logic [63:0]    rt_x    [1:SQ];
	logic [33:0]    rt_rem  [1:SQ];
	logic [31:0]    rt_root [1:SQ];
	cfcp_pkg::ctx_t rt_ctx  [1:SQ];

	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		logic           v_c;
		logic [63:0]    x_c;
		logic [33:0]    rem_c;
		logic [31:0]    root_c;
		cfcp_pkg::ctx_t ctx_c;
		logic [35:0]    t;
		logic [35:0]    trial;
		logic [33:0]    rem_n;
		logic [31:0]    root_n;

		if (k == 0) begin : g_first
			assign v_c    = v_s8;
			assign x_c    = sq_s8;
			assign rem_c  = '0;
			assign root_c = '0;
			assign ctx_c  = ctx_s8;
		end else begin : g_rest
			assign v_c    = rt_v[k];
			assign x_c    = rt_x[k];
			assign rem_c  = rt_rem[k];
			assign root_c = rt_root[k];
			assign ctx_c  = rt_ctx[k];
		end

		// Try to subtract 4 * root + 1 from the extended remainder.
		always_comb begin
			t     = {rem_c, x_c[63:62]};
			trial = {2'b00, root_c, 2'b01};
			if (t >= trial) begin
				rem_n  = 34'(t - trial);
				root_n = {root_c[30:0], 1'b1};
			end else begin
				rem_n  = t[33:0];
				root_n = {root_c[30:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v[k+1] <= 1'b0;
			end else if (adv) begin
				rt_v[k+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_x[k+1]    <= {x_c[61:0], 2'b00};
				rt_rem[k+1]  <= rem_n;
				rt_root[k+1] <= root_n;
				rt_ctx[k+1]  <= ctx_c;
			end
		end
	end

	// Stage 9: scaling products |f| * r.
	cfcp_pkg::ctx_t ctx_c9;
	logic           v_s9;
	cfcp_pkg::ctx_t ctx_s9;
	logic [63:0]    pa_s9;
	logic [63:0]    pb_s9;
	always_comb begin
		ctx_c9      = rt_ctx[SQ];
		ctx_c9.norm = rt_root[SQ];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= rt_v[SQ];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s9 <= ctx_c9;
			pa_s9  <= 64'(rt_ctx[SQ].ma) * 64'(rt_ctx[SQ].r);
			pb_s9  <= 64'(rt_ctx[SQ].mb) * 64'(rt_ctx[SQ].r);
		end
	end

	// Cone division: |f| * r / norm.
	logic [1:0][cfcp_pkg::DIV_W-1:0] c_dvd;
	logic [1:0][cfcp_pkg::DVS_W-1:0] c_dvs;
	logic                            c_v;
	logic [1:0][cfcp_pkg::DIV_W-1:0] c_q;
	cfcp_pkg::ctx_t                  c_ctx;
	assign c_dvd[0] = pa_s9;
	assign c_dvd[1] = pb_s9;
	assign c_dvs[0] = ctx_s9.norm;
	assign c_dvs[1] = ctx_s9.norm;

	cfcp_div u_div_c (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s9),
		.dividend(c_dvd), .divisor(c_dvs), .ctx_in(ctx_s9),
		.out_valid(c_v), .quotient(c_q), .ctx_out(c_ctx)
	);

	// Stage 10: response register.
	logic [31:0]        qsa;
	logic [31:0]        qsb;
	logic signed [31:0] fa_o;
	logic signed [31:0] fb_o;
	cfcp_pkg::rsp_t     rsp_c;
	logic               vout_q;
	cfcp_pkg::rsp_t     rsp_q;
	always_comb begin
		qsa  = c_q[0][31:0];
		qsb  = c_q[1][31:0];
		fa_o = c_ctx.fa;
		fb_o = c_ctx.fb;
		if (c_ctx.need) begin
			fa_o = c_ctx.fa[31] ? -$signed(qsa) : $signed(qsa);
			fb_o = c_ctx.fb[31] ? -$signed(qsb) : $signed(qsb);
		end
		if (c_ctx.rel) begin
			rsp_c.new_force_normal    = '0;
			rsp_c.new_force_tangent_a = '0;
			rsp_c.new_force_tangent_b = '0;
			rsp_c.new_viol_tangent_a  = c_ctx.va_in;
			rsp_c.new_viol_tangent_b  = c_ctx.vb_in;
			rsp_c.contact_active      = 1'b0;
		end else begin
			rsp_c.new_force_normal    = c_ctx.fn;
			rsp_c.new_force_tangent_a = fa_o;
			rsp_c.new_force_tangent_b = fb_o;
			rsp_c.new_viol_tangent_a  = c_ctx.va;
			rsp_c.new_viol_tangent_b  = c_ctx.vb;
			rsp_c.contact_active      = (c_ctx.fn != '0);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout_q <= 1'b0;
		end else if (adv) begin
			vout_q <= c_v;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_c;
		end
	end

	assign rsp.valid = vout_q;
	assign rsp.data  = rsp_q;

	// A frozen pipeline keeps its first stage.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> v_s1 == $past(v_s1))
		else $error("first stage changed during a stall");

	// A released contact leaves no normal force.
	a_rel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && ctx_s3.rel |-> ctx_s3.fn == '0)
		else $error("released contact with nonzero normal force");

	// Scaling only happens when the norm reaches the cone radius.
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 && ctx_s9.need |-> ctx_s9.norm >= ctx_s9.r)
		else $error("square root below cone radius");

	// A nonzero normal force marks the contact active.
	a_active: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.new_force_normal != '0 |-> rsp.data.contact_active)
		else $error("active flag missing");

endmodule

FILE: tb/tb_contact_friction_cone_projection.sv
// Self-checking testbench of the contact friction cone projection block.
module tb_contact_friction_cone_projection;

	localparam logic [2:0] IDX_SPARE_LO = 3'd6;
	localparam logic [2:0] IDX_SPARE_HI = 3'd7;
	localparam logic [31:0] WMAX = 32'h7FFF_FFFF;
	localparam logic [31:0] WMIN = 32'h8000_0000;
	localparam int LATENCY = 234;
	localparam int LONG_HOLD = 600;
	localparam int RAND_PHASES = 7;
	localparam int ITEMS_PER_PHASE = 178;

	typedef struct {
		cfcp_pkg::req_t q;
		bit             known;
		cfcp_pkg::rsp_t r;
	} row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [2:0]                 cfg_idx;
	logic [cfcp_pkg::CFG_W-1:0] cfg_wdata;

	cfcp_req_if req_ch ();
	cfcp_rsp_if rsp_ch ();

	contact_friction_cone_projection i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Shadow copies of the compliance and friction registers.
	logic [30:0] k_nn;
	longint      k_nt_a;
	longint      k_nt_b;
	logic [29:0] k_tt_a;
	logic [29:0] k_tt_b;
	logic [20:0] k_mu;

	cfcp_pkg::rsp_t pending_forces[$];
	row_t           dir_rows[$];
	int             errors = 0;
	bit             calm = 0;
	bit             long_hold_req = 0;

	// Clock with period 8.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Time limit for a hung run.
	initial begin
		#(8 * 2_000_000);
		$display("tb_contact_friction_cone_projection NOT OK");
		$finish;
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned floor_sqrt64(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint onto_cone(longint f, longint unsigned r, longint unsigned nrm);
		longint unsigned mag;
		longint unsigned qt;
		mag = (f < 0) ? longint'(-f) : f;
		qt = (mag * r) / nrm;
		return (f < 0) ? -longint'(qt) : longint'(qt);
	endfunction

	// One Gauss-Seidel contact step under the current register settings.
	function automatic cfcp_pkg::rsp_t project_contact(cfcp_pkg::req_t q);
		longint vn, va, vb, pn, pa, pb, nn, tsum, fn, dn, fa, fb;
		longint unsigned r, ma, mb, sq, nrm;
		cfcp_pkg::rsp_t o;
		vn = q.viol_normal;
		va = q.viol_tangent_a;
		vb = q.viol_tangent_b;
		pn = q.prev_force_normal;
		pa = q.prev_force_tangent_a;
		pb = q.prev_force_tangent_b;
		nn = (k_nn == 0) ? 64'sd1 : longint'(k_nn);
		tsum = longint'(k_tt_a) + longint'(k_tt_b);
		if (tsum == 0)
			tsum = 1;
		o = '0;
		fn = pn - (vn * 65536) / nn;
		// Contact released: forces drop to zero, violations pass through.
		if (fn < 0) begin
			o.new_viol_tangent_a = va[31:0];
			o.new_viol_tangent_b = vb[31:0];
			return o;
		end
		if (fn > 64'sd2147483647)
			fn = 64'sd2147483647;
		dn = fn - pn;
		va = sat32(va + ((k_nt_a * dn) >>> 16));
		vb = sat32(vb + ((k_nt_b * dn) >>> 16));
		fa = sat32(pa - (2 * va * 65536) / tsum);
		fb = sat32(pb - (2 * vb * 65536) / tsum);
		r = (longint'(fn) * longint'(k_mu)) >> 16;
		// Scale the tangent pair back onto the cone when it lies outside.
		if (r < 64'h1_0000_0000) begin
			ma = (fa < 0) ? -fa : fa;
			mb = (fb < 0) ? -fb : fb;
			sq = ma * ma + mb * mb;
			if (sq > r * r) begin
				nrm = floor_sqrt64(sq);
				fa = onto_cone(fa, r, nrm);
				fb = onto_cone(fb, r, nrm);
			end
		end
		o.new_force_normal = fn[30:0];
		o.new_force_tangent_a = fa[31:0];
		o.new_force_tangent_b = fb[31:0];
		o.new_viol_tangent_a = va[31:0];
		o.new_viol_tangent_b = vb[31:0];
		o.contact_active = (fn != 0);
		return o;
	endfunction

	function automatic cfcp_pkg::req_t mkreq(logic [31:0] vn, logic [31:0] va,
			logic [31:0] vb, logic [31:0] pn, logic [31:0] pa, logic [31:0] pb);
		cfcp_pkg::req_t q;
		q.viol_normal = vn;
		q.viol_tangent_a = va;
		q.viol_tangent_b = vb;
		q.prev_force_normal = pn;
		q.prev_force_tangent_a = pa;
		q.prev_force_tangent_b = pb;
		return q;
	endfunction

	function automatic cfcp_pkg::rsp_t mkrsp(logic [30:0] fn, logic [31:0] fa,
			logic [31:0] fb, logic [31:0] va, logic [31:0] vb, logic act);
		cfcp_pkg::rsp_t o;
		o.new_force_normal = fn;
		o.new_force_tangent_a = fa;
		o.new_force_tangent_b = fb;
		o.new_viol_tangent_a = va;
		o.new_viol_tangent_b = vb;
		o.contact_active = act;
		return o;
	endfunction

	// A word that is either unrestricted, an extreme, or of small magnitude.
	function automatic logic [31:0] pick_word(int span);
		logic [31:0] w;
		case ($urandom_range(0, 5))
			0: begin
				w = $urandom;
			end
			1: begin
				case ($urandom_range(0, 3))
					0: w = WMAX;
					1: w = WMIN;
					2: w = '1;
					default: w = '0;
				endcase
			end
			default: begin
				w = $urandom_range(0, (1 << span) - 1);
				if ($urandom_range(0, 1))
					w = -w;
			end
		endcase
		return w;
	endfunction

	// Mostly contacts that stay closed, with some fully random requests.
	function automatic cfcp_pkg::req_t random_contact();
		cfcp_pkg::req_t q;
		if ($urandom_range(0, 3) == 0) begin
			q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end else begin
			q = mkreq(pick_word($urandom_range(4, 20)), pick_word($urandom_range(8, 26)),
				pick_word($urandom_range(8, 26)), $urandom_range(0, 32'h00FF_FFFF),
				pick_word($urandom_range(8, 28)), pick_word($urandom_range(8, 28)));
		end
		return q;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Register write; the caller lowers the write enable after the batch.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			cfcp_pkg::REG_NN:   k_nn = val[30:0];
			cfcp_pkg::REG_NT_A: k_nt_a = longint'(signed'(val));
			cfcp_pkg::REG_NT_B: k_nt_b = longint'(signed'(val));
			cfcp_pkg::REG_TT_A: k_tt_a = val[29:0];
			cfcp_pkg::REG_TT_B: k_tt_b = val[29:0];
			cfcp_pkg::REG_MU:   k_mu = val[20:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_forces.size() != 0)
			@(posedge clk);
	endtask

	task automatic configure(logic [31:0] nn, logic [31:0] nta, logic [31:0] ntb,
			logic [31:0] tta, logic [31:0] ttb, logic [31:0] mu);
		wait_drained();
		write_reg(cfcp_pkg::REG_NN, nn);
		write_reg(cfcp_pkg::REG_NT_A, nta);
		write_reg(cfcp_pkg::REG_NT_B, ntb);
		write_reg(cfcp_pkg::REG_TT_A, tta);
		write_reg(cfcp_pkg::REG_TT_B, ttb);
		write_reg(cfcp_pkg::REG_MU, mu);
		cfg_we <= 1'b0;
	endtask

	// Offer one request, hold it until accepted, and record its expected response.
	task automatic send_contact(cfcp_pkg::req_t q, bit known, cfcp_pkg::rsp_t want);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.data <= q;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_forces.push_back(known ? want : project_contact(q));
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 13);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Response side: random stalls, one long hold, and the comparison.
	initial begin
		int stall_left;
		cfcp_pkg::rsp_t got;
		cfcp_pkg::rsp_t want;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (long_hold_req) begin
				long_hold_req = 0;
				stall_left = LONG_HOLD - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (pending_forces.size() == 0) begin
					report_mismatch("unexpected response", 32'(got.new_force_normal), '0);
				end else begin
					want = pending_forces.pop_front();
					check_field("new_force_normal", 32'(got.new_force_normal),
						32'(want.new_force_normal));
					check_field("new_force_tangent_a", got.new_force_tangent_a,
						want.new_force_tangent_a);
					check_field("new_force_tangent_b", got.new_force_tangent_b,
						want.new_force_tangent_b);
					check_field("new_viol_tangent_a", got.new_viol_tangent_a,
						want.new_viol_tangent_a);
					check_field("new_viol_tangent_b", got.new_viol_tangent_b,
						want.new_viol_tangent_b);
					check_field("contact_active", 32'(got.contact_active),
						32'(want.contact_active));
				end
			end
		end
	end

	// Reset, directed table, then random phases under changing settings.
	initial begin
		int waited;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		k_nn = 31'd65536;
		k_nt_a = 0;
		k_nt_b = 0;
		k_tt_a = 30'd65536;
		k_tt_b = 30'd65536;
		k_mu = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults after reset: unit compliances, no coupling, no friction.
		dir_rows.push_back('{mkreq(0, 0, 0, 0, 0, 0), 1'b1, mkrsp(0, 0, 0, 0, 0, 1'b0)});
		// Released contact keeps the input tangent violations.
		dir_rows.push_back('{mkreq(1, WMAX, WMIN, 0, 123, -5), 1'b1,
			mkrsp(0, 0, 0, WMAX, WMIN, 1'b0)});
		// Normal force saturates at the top of its range.
		dir_rows.push_back('{mkreq(WMIN, 0, 0, WMAX, 0, 0), 1'b1,
			mkrsp(31'h7FFF_FFFF, 0, 0, 0, 0, 1'b1)});
		// Zero normal force: the zero-radius cone clears the tangents.
		dir_rows.push_back('{mkreq(65536, 65536, -65536, 65536, WMAX, WMIN), 1'b1,
			mkrsp(0, 0, 0, 65536, -65536, 1'b0)});
		dir_rows.push_back('{mkreq(0, WMIN, WMAX, WMAX, WMIN, WMAX), 1'b0, '0});
		dir_rows.push_back('{mkreq(WMIN, WMAX, WMIN, WMAX, WMAX, WMIN), 1'b0, '0});
		dir_rows.push_back('{mkreq('1, '1, '1, 0, '1, '1), 1'b0, '0});
		dir_rows.push_back('{mkreq(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN), 1'b0, '0});
		dir_rows.push_back('{mkreq(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX), 1'b0, '0});
		dir_rows.push_back('{mkreq(-32768, 40000, -70000, 200000, 9000, -9000), 1'b0, '0});
		foreach (dir_rows[i])
			send_contact(dir_rows[i].q, dir_rows[i].known, dir_rows[i].r);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			req_ch.valid <= 1'b0;
			case (ph)
				0: configure(WMIN, WMIN, WMAX, 0, 0, 32'h0010_0000);
				1: configure(WMAX, WMAX, WMIN, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 0);
				2: configure(1, $urandom_range(0, 32'h3_FFFF) - 32'h2_0000,
					$urandom, $urandom_range(0, 32'h4_0000), 0, $urandom_range(0, 32'h10_0000));
				default: configure($urandom_range(1, 32'h0004_0000),
					$urandom_range(0, 32'h3_FFFF) - 32'h2_0000,
					$urandom_range(0, 32'h3_FFFF) - 32'h2_0000,
					$urandom_range(0, 32'h4_0000), $urandom_range(1, 32'h4_0000),
					$urandom_range(0, 32'h10_0000));
			endcase
			// Writes to spare indexes must leave every register alone.
			if (ph == 0) begin
				write_reg(IDX_SPARE_LO, $urandom);
				write_reg(IDX_SPARE_HI, $urandom);
				cfg_we <= 1'b0;
			end
			if (ph == 1)
				long_hold_req = 1;
			if (ph == RAND_PHASES - 1)
				calm = 1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 3 && n == ITEMS_PER_PHASE / 2) begin
					req_ch.valid <= 1'b0;
					wait_drained();
				end
				send_contact(random_contact(), 1'b0, '0);
			end
		end
		req_ch.valid <= 1'b0;

		waited = 0;
		while (pending_forces.size() != 0 && waited < 100_000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_forces.size() != 0)
			report_mismatch("missing responses", 32'(pending_forces.size()), '0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) begin
			$display("tb_contact_friction_cone_projection OK");
		end else begin
			$display("tb_contact_friction_cone_projection NOT OK");
		end
		$finish;
	end

endmodule
